// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/mxw_pkg.sv
// ----------------------------------------------------------------------------
// mxw_pkg
// Shared types and constants of the interval window counter.
// ----------------------------------------------------------------------------
package mxw_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 31;
    localparam int BEST_W = 11;
    localparam logic [BEST_W-1:0] BEST_MAX = 11'd2047;

    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_ACCUM,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic shift_in;
        logic load_tok;
        logic rotate;
        logic accum;
    } ctrl_t;

endpackage

// File: rtl/core/max_intervals_in_window_core.sv
// ----------------------------------------------------------------------------
// max_intervals_in_window_core
// Loads intervals one beat per cycle; on the last beat reports the largest
// number of stored intervals that fit inside one window of set length.
// Evaluation: after the last input beat come a prep state, a counting ring pass
//   and a max-taking ring pass over all MAX_INTERVALS cells, then a flush state
//   that registers the result once the output register is free.
// Throughput: one interval beat per cycle while loading; no beats taken while
//   the evaluation runs or while the flush waits for the previous result to be taken.
// Reset: clears fill count, drop flag, window_length and control; stores are
//   not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_intervals_in_window_core #(
    parameter int MAX_INTERVALS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] endpoint_a, [63:32] endpoint_b
    input  logic        s_axis_tlast,   // last_interval
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [10:0] best_count, [11] overflow, zero pad
);

    localparam int N      = MAX_INTERVALS;
    localparam int FILL_W = $clog2(N + 1);
    localparam int CNT_W  = $clog2(N + 1);
    localparam int PH_W   = (N > 1) ? $clog2(N) : 1;
    localparam int SAT_W  = (CNT_W > mxw_pkg::BEST_W) ? CNT_W : mxw_pkg::BEST_W;

    mxw_pkg::state_t state_reg, state_next;
    mxw_pkg::ctrl_t  ctrl;

    logic [mxw_pkg::LEN_W-1:0]  window_length_reg;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       dropped_reg, dropped_next;
    logic [PH_W-1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]           best_reg, best_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mxw_pkg::BEST_W-1:0] out_best_reg, out_best_next;
    logic                       out_ovf_reg, out_ovf_next;

    logic                              s_accept;
    logic                              cfg_write;
    logic                              store_full;
    logic                              phase_done;
    logic                              out_free;
    logic signed [mxw_pkg::DATA_W-1:0] ep_a;
    logic signed [mxw_pkg::DATA_W-1:0] ep_b;
    logic signed [mxw_pkg::DATA_W-1:0] lo_ep;
    logic signed [mxw_pkg::DATA_W-1:0] hi_ep;
    logic [CNT_W-1:0]                  tail_cnt;
    logic [SAT_W-1:0]                  best_wide;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == mxw_pkg::REG_WINDOW_LENGTH);
    assign prdata    = (paddr[2] == mxw_pkg::REG_WINDOW_LENGTH)
                     ? {1'b0, window_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            window_length_reg <= pwdata[mxw_pkg::LEN_W-1:0];
        end
    end

    assign ep_a  = s_axis_tdata[31:0];
    assign ep_b  = s_axis_tdata[63:32];
    assign lo_ep = (ep_a < ep_b) ? ep_a : ep_b;
    assign hi_ep = (ep_a < ep_b) ? ep_b : ep_a;

    assign s_axis_tready = (state_reg == mxw_pkg::ST_LOAD);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign store_full    = (fill_reg == FILL_W'(N));
    assign phase_done    = (phase_reg == PH_W'(N - 1));
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign best_wide     = SAT_W'(best_reg);

    mxw_chain #(
        .CELLS (N),
        .CNT_W (CNT_W),
        .FILL_W(FILL_W)
    ) u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .fill         (fill_reg),
        .window_length(window_length_reg),
        .head_start   (lo_ep),
        .head_end     (hi_ep),
        .tail_cnt     (tail_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mxw_pkg::ST_LOAD;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            phase_reg     <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            phase_reg     <= phase_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_best_reg <= out_best_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        phase_next     = phase_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_best_next  = out_best_reg;
        out_ovf_next   = out_ovf_reg;
        ctrl           = '0;

        case (state_reg)
            mxw_pkg::ST_LOAD:
            begin
                if (s_accept)
                begin
                    if (store_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.shift_in = 1'b1;
                        fill_next     = fill_reg + FILL_W'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = mxw_pkg::ST_PREP;
                    end
                end
            end
            mxw_pkg::ST_PREP:
            begin
                ctrl.load_tok = 1'b1;
                phase_next    = '0;
                best_next     = '0;
                state_next    = mxw_pkg::ST_ACCUM;
            end
            mxw_pkg::ST_ACCUM:
            begin
                ctrl.accum  = 1'b1;
                ctrl.rotate = 1'b1;
                phase_next  = phase_reg + PH_W'(1);
                if (phase_done)
                begin
                    phase_next = '0;
                    state_next = mxw_pkg::ST_SCAN;
                end
            end
            mxw_pkg::ST_SCAN:
            begin
                ctrl.rotate = 1'b1;
                phase_next  = phase_reg + PH_W'(1);
                if (tail_cnt > best_reg)
                begin
                    best_next = tail_cnt;
                end
                if (phase_done)
                begin
                    phase_next = '0;
                    state_next = mxw_pkg::ST_FLUSH;
                end
            end
            mxw_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_best_next  = (best_wide > SAT_W'(mxw_pkg::BEST_MAX))
                                   ? mxw_pkg::BEST_MAX
                                   : best_wide[mxw_pkg::BEST_W-1:0];
                    out_ovf_next   = dropped_reg;
                    fill_next      = '0;
                    dropped_next   = 1'b0;
                    state_next     = mxw_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mxw_pkg::ST_LOAD;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_ovf_reg, out_best_reg};

    `ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(N))
    `ASSERT_NXT(a_last_starts_eval, clk, rst_n, s_accept && s_axis_tlast, state_reg == mxw_pkg::ST_PREP)
    `ASSERT_IMP(a_drop_only_when_full, clk, rst_n, $rose(dropped_reg), $past(fill_reg) == FILL_W'(N))
    `ASSERT_IMP(a_flush_clears, clk, rst_n, $past(state_reg) == mxw_pkg::ST_FLUSH && state_reg == mxw_pkg::ST_LOAD, fill_reg == '0 && !dropped_reg && out_valid_reg)

endmodule

// File: rtl/core/mxw_cell.sv
// ----------------------------------------------------------------------------
// mxw_cell
// One chain cell: holds one interval and one circulating candidate token.
// ----------------------------------------------------------------------------
module mxw_cell #(
    parameter int CNT_W = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mxw_pkg::ctrl_t                    ctrl,
    input  logic                              active,
    input  logic [mxw_pkg::LEN_W-1:0]         window_length,
    input  logic signed [mxw_pkg::DATA_W-1:0] up_start,
    input  logic signed [mxw_pkg::DATA_W-1:0] up_end,
    input  logic signed [mxw_pkg::DATA_W-1:0] up_e,
    input  logic [CNT_W-1:0]                  up_cnt,
    input  logic                              up_vld,
    output logic signed [mxw_pkg::DATA_W-1:0] dn_start,
    output logic signed [mxw_pkg::DATA_W-1:0] dn_end,
    output logic signed [mxw_pkg::DATA_W-1:0] dn_e,
    output logic [CNT_W-1:0]                  dn_cnt,
    output logic                              dn_vld
);

    logic signed [mxw_pkg::DATA_W-1:0] start_reg;
    logic signed [mxw_pkg::DATA_W-1:0] end_reg;
    logic signed [mxw_pkg::DATA_W-1:0] tok_e_reg;
    logic [CNT_W-1:0]                  tok_cnt_reg;
    logic                              tok_vld_reg;
    logic signed [mxw_pkg::DATA_W:0]   span;
    logic                              hit;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_in)
        begin
            start_reg <= up_start;
            end_reg   <= up_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_tok)
        begin
            tok_e_reg   <= end_reg;
            tok_cnt_reg <= '0;
        end
        else if (ctrl.rotate)
        begin
            tok_e_reg   <= up_e;
            tok_cnt_reg <= up_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else if (ctrl.load_tok)
        begin
            tok_vld_reg <= active;
        end
        else if (ctrl.rotate)
        begin
            tok_vld_reg <= up_vld;
        end
    end

    // token end minus interval start must not exceed the window length
    assign span = {tok_e_reg[mxw_pkg::DATA_W-1], tok_e_reg}
                - {start_reg[mxw_pkg::DATA_W-1], start_reg};

    assign hit = ctrl.accum && active && tok_vld_reg && (end_reg <= tok_e_reg)
              && (span <= $signed({2'b00, window_length}));

    assign dn_start = start_reg;
    assign dn_end   = end_reg;
    assign dn_e     = tok_e_reg;
    assign dn_cnt   = tok_cnt_reg + CNT_W'(hit);
    assign dn_vld   = tok_vld_reg;

endmodule

// File: rtl/core/mxw_chain.sv
// ----------------------------------------------------------------------------
// mxw_chain
// Row of cells: intervals shift in at the head, candidate tokens run a ring.
// ----------------------------------------------------------------------------
module mxw_chain #(
    parameter int CELLS = 1024,
    parameter int CNT_W = 11,
    parameter int FILL_W = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mxw_pkg::ctrl_t                    ctrl,
    input  logic [FILL_W-1:0]                 fill,
    input  logic [mxw_pkg::LEN_W-1:0]         window_length,
    input  logic signed [mxw_pkg::DATA_W-1:0] head_start,
    input  logic signed [mxw_pkg::DATA_W-1:0] head_end,
    output logic [CNT_W-1:0]                  tail_cnt
);

    logic signed [mxw_pkg::DATA_W-1:0] st_w  [CELLS];
    logic signed [mxw_pkg::DATA_W-1:0] en_w  [CELLS];
    logic signed [mxw_pkg::DATA_W-1:0] e_w   [CELLS];
    logic [CNT_W-1:0]                  cnt_w [CELLS];
    logic                              vld_w [CELLS];

    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        localparam int UP = (k == 0) ? CELLS - 1 : k - 1;
        logic signed [mxw_pkg::DATA_W-1:0] in_start;
        logic signed [mxw_pkg::DATA_W-1:0] in_end;
        logic                              active;

        if (k == 0)
        begin : g_head
            assign in_start = head_start;
            assign in_end   = head_end;
        end
        else
        begin : g_body
            assign in_start = st_w[k-1];
            assign in_end   = en_w[k-1];
        end

        assign active = (FILL_W'(k) < fill);

        mxw_cell #(
            .CNT_W(CNT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .active       (active),
            .window_length(window_length),
            .up_start     (in_start),
            .up_end       (in_end),
            .up_e         (e_w[UP]),
            .up_cnt       (cnt_w[UP]),
            .up_vld       (vld_w[UP]),
            .dn_start     (st_w[k]),
            .dn_end       (en_w[k]),
            .dn_e         (e_w[k]),
            .dn_cnt       (cnt_w[k]),
            .dn_vld       (vld_w[k])
        );
    end

    assign tail_cnt = cnt_w[CELLS-1];

endmodule
